[src/tcpq_pkg.sv]
// Package for the two-class priority queue.
// Holds the operation, status and cell command codes shared by the cell row and the top level.
// No dependencies.
`default_nettype none

package tcpq_pkg;

  localparam int unsigned IdW    = 16;
  localparam int unsigned AgeW   = 8;
  localparam int unsigned LenW   = 5;
  localparam logic [AgeW-1:0] PrefAgeReset = 8'd60;

  // Operation selector of an input word
  typedef enum logic [1:0] {
    FUNC_JOIN  = 2'd0,
    FUNC_SERVE = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // Command broadcast to every cell of the row
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_PULL   = 2'd1,
    CELL_INSERT = 2'd2
  } cell_op_e;

  // Broadcast control word: command plus the key / new entry
  typedef struct packed {
    cell_op_e            op;
    logic [IdW-1:0]      key_id;
    logic [AgeW-1:0]     key_age;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[src/two_class_priority_queue.sv]
// Top level of the two-class priority queue: input register, cell row, control and
// output register. Uses tcpq_pkg and tcpq_cell.
//
// Two-class priority queue. Each accepted word is held in an input register, then
// executed against a row of CAPACITY cells: all cells compare their id with the key at
// once, and a join or serve shifts entries one place between neighboring cells. The
// result word is loaded into the output register when the word executes and is held
// there until taken. A new word is accepted every cycle as long as the output side does
// not stall; a stalled result holds the word under execution, and the input stalls
// behind it. preferential_age is written through cfg_we_i / cfg_data_i; the user must
// write it only while idle, which the block itself does not enforce. It resets to 60.
// Entries are not cleared at reset; only occupied cells are ever read.
`default_nettype none

module two_class_priority_queue
  import tcpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire  logic              clk_i,
  input  wire  logic              rst_ni,
  input  wire  logic              cfg_we_i,
  input  wire  logic [AgeW-1:0]   cfg_data_i,
  input  wire  logic              in_valid_i,
  output logic                    in_stall_o,
  input  wire  logic [1:0]        func_i,
  input  wire  logic [IdW-1:0]    person_id_i,
  input  wire  logic [AgeW-1:0]   person_age_i,
  output logic                    out_valid_o,
  input  wire  logic              out_stall_i,
  output logic [2:0]              status_o,
  output logic [IdW-1:0]          served_id_o,
  output logic [AgeW-1:0]         reported_age_o,
  output logic [LenW-1:0]         queue_length_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapC = CntW'(CAPACITY);

  // Configuration
  logic [AgeW-1:0] pref_age_q;

  // Input register
  logic            op_valid_q, op_valid_d;
  func_e           op_func_q;
  logic [IdW-1:0]  op_id_q;
  logic [AgeW-1:0] op_age_q;

  // Queue bookkeeping
  logic [CntW-1:0] occ_q, occ_d;
  logic [CntW-1:0] pref_q, pref_d;

  // Output register
  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  logic [IdW-1:0]  served_q, served_d;
  logic [AgeW-1:0] rep_age_q, rep_age_d;
  logic [LenW-1:0] len_q, len_d;

  logic accept, exec;

  // Cell row wiring
  cell_ctrl_t      ctrl;
  logic [CntW-1:0] pos;
  logic [IdW-1:0]  cell_id  [CAPACITY];
  logic [AgeW-1:0] cell_age [CAPACITY];
  logic [AgeW-1:0] hit_age  [CAPACITY];
  logic [CAPACITY-1:0] hit_vec;
  logic            any_hit;
  logic [AgeW-1:0] found_age;

  // Handshake
  assign exec       = op_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = op_valid_q && !exec;
  assign accept     = in_valid_i && !in_stall_o;
  assign op_valid_d = accept || (op_valid_q && !exec);
  assign out_valid_d = exec || (out_valid_q && out_stall_i);

  // Build the cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [IdW-1:0]  prev_id, next_id;
    logic [AgeW-1:0] prev_age, next_age;

    if (g == 0) begin : g_first
      assign prev_id  = '0;
      assign prev_age = '0;
    end else begin : g_mid
      assign prev_id  = cell_id[g-1];
      assign prev_age = cell_age[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign next_id  = cell_id[g];
      assign next_age = cell_age[g];
    end else begin : g_inner
      assign next_id  = cell_id[g+1];
      assign next_age = cell_age[g+1];
    end

    tcpq_cell #(
      .Index (g),
      .CntW  (CntW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .pos_i      (pos),
      .occ_i      (occ_q),
      .prev_id_i  (prev_id),
      .prev_age_i (prev_age),
      .next_id_i  (next_id),
      .next_age_i (next_age),
      .id_o       (cell_id[g]),
      .age_o      (cell_age[g]),
      .hit_o      (hit_vec[g]),
      .hit_age_o  (hit_age[g])
    );
  end

  // Combine match results; ids are unique so at most one cell hits
  always_comb begin
    found_age = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found_age = found_age | hit_age[i];
    end
  end
  assign any_hit = |hit_vec;

  // Execute the held word
  always_comb begin
    ctrl.op      = CELL_HOLD;
    ctrl.key_id  = op_id_q;
    ctrl.key_age = op_age_q;
    pos          = occ_q;
    occ_d        = occ_q;
    pref_d       = pref_q;
    status_d     = ST_OK;
    served_d     = '0;
    rep_age_d    = '0;

    unique case (op_func_q)
      FUNC_JOIN: begin
        if (any_hit) begin
          status_d = ST_DUP;
        end else if (occ_q == CapC) begin
          status_d = ST_FULL;
        end else begin
          ctrl.op = exec ? CELL_INSERT : CELL_HOLD;
          occ_d   = occ_q + 1'b1;
          if (op_age_q >= pref_age_q) begin
            pos    = (pref_q > occ_q) ? occ_q : pref_q;
            pref_d = pos + 1'b1;
          end
        end
      end
      FUNC_SERVE: begin
        if (occ_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl.op  = exec ? CELL_PULL : CELL_HOLD;
          served_d = cell_id[0];
          occ_d    = occ_q - 1'b1;
          if (pref_q != '0) begin
            pref_d = pref_q - 1'b1;
          end
        end
      end
      FUNC_QUERY: begin
        if (any_hit) begin
          rep_age_d = found_age;
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase

    len_d = LenW'(occ_d);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      occ_q       <= '0;
      pref_q      <= '0;
      pref_age_q  <= PrefAgeReset;
    end else begin
      op_valid_q  <= op_valid_d;
      out_valid_q <= out_valid_d;
      if (exec) begin
        occ_q  <= occ_d;
        pref_q <= pref_d;
      end
      if (cfg_we_i) begin
        pref_age_q <= cfg_data_i;
      end
    end
  end

  // Payload registers: capture input word, load result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_func_q <= func_e'(func_i);
      op_id_q   <= person_id_i;
      op_age_q  <= person_age_i;
    end
    if (exec) begin
      status_q  <= status_d;
      served_q  <= served_d;
      rep_age_q <= rep_age_d;
      len_q     <= len_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign served_id_o    = served_q;
  assign reported_age_o = rep_age_q;
  assign queue_length_o = len_q;

endmodule

`default_nettype wire

[src/tcpq_cell.sv]
// One storage cell of the queue row: holds one entry, compares it against the key
// and takes its next value from itself, its neighbors or the new entry. Uses tcpq_pkg.
`default_nettype none

module tcpq_cell
  import tcpq_pkg::*;
#(
  parameter int unsigned Index = 0,
  parameter int unsigned CntW  = 5
) (
  input  wire  logic             clk_i,
  input  wire  cell_ctrl_t       ctrl_i,
  input  wire  logic [CntW-1:0]  pos_i,
  input  wire  logic [CntW-1:0]  occ_i,
  input  wire  logic [IdW-1:0]   prev_id_i,
  input  wire  logic [AgeW-1:0]  prev_age_i,
  input  wire  logic [IdW-1:0]   next_id_i,
  input  wire  logic [AgeW-1:0]  next_age_i,
  output logic [IdW-1:0]         id_o,
  output logic [AgeW-1:0]        age_o,
  output logic                   hit_o,
  output logic [AgeW-1:0]        hit_age_o
);

  localparam logic [CntW-1:0] MyIdx = CntW'(Index);

  logic [IdW-1:0]  id_q,  id_d;
  logic [AgeW-1:0] age_q, age_d;

  // Match only while this cell lies inside the occupied part
  assign hit_o     = (MyIdx < occ_i) && (id_q == ctrl_i.key_id);
  assign hit_age_o = hit_o ? age_q : '0;
  assign id_o      = id_q;
  assign age_o     = age_q;

  // Pick the next entry
  always_comb begin
    id_d  = id_q;
    age_d = age_q;
    unique case (ctrl_i.op)
      CELL_HOLD: begin
        id_d  = id_q;
        age_d = age_q;
      end
      CELL_PULL: begin
        id_d  = next_id_i;
        age_d = next_age_i;
      end
      CELL_INSERT: begin
        if (MyIdx > pos_i) begin
          id_d  = prev_id_i;
          age_d = prev_age_i;
        end else if (MyIdx == pos_i) begin
          id_d  = ctrl_i.key_id;
          age_d = ctrl_i.key_age;
        end
      end
      default: begin
        id_d  = id_q;
        age_d = age_q;
      end
    endcase
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    age_q <= age_d;
  end

endmodule

`default_nettype wire

[test/tb_two_class_priority_queue.sv]
// Self-checking testbench for two_class_priority_queue: directed and random words,
// a queue scoreboard that predicts every result, random input gaps and output stalls.
// Depends on tcpq_pkg and the two_class_priority_queue RTL.
`default_nettype none

module tb_two_class_priority_queue
  import tcpq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QueueDepth = 16;

  // One result word as the block should present it
  typedef struct packed {
    status_e         status;
    logic [IdW-1:0]  served;
    logic [AgeW-1:0] age;
    logic [LenW-1:0] len;
  } queue_result_t;

  // Holds a mirror of the queue and the results still owed by the block
  class queue_scoreboard;
    logic [IdW-1:0]  held_ids[$];
    logic [AgeW-1:0] held_ages[$];
    int unsigned     pref_count;
    logic [AgeW-1:0] pref_age;
    queue_result_t   owed_q[$];
    int unsigned     errors;

    function new();
      pref_count = 0;
      pref_age   = PrefAgeReset;
      errors     = 0;
    endfunction

    function int find_id(logic [IdW-1:0] id);
      foreach (held_ids[i]) begin
        if (held_ids[i] == id) return i;
      end
      return -1;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Apply an accepted word to the mirror and queue up the result it owes
    function void note_word(func_e f, logic [IdW-1:0] id, logic [AgeW-1:0] age);
      queue_result_t r;
      int            slot;
      int unsigned   pos;
      r        = '0;
      r.status = ST_OK;
      slot     = find_id(id);
      case (f)
        FUNC_JOIN: begin
          if (slot >= 0) begin
            r.status = ST_DUP;
          end else if (held_ids.size() >= QueueDepth) begin
            r.status = ST_FULL;
          end else if (age >= pref_age) begin
            // land right behind the last preferred entry
            pos = (pref_count > held_ids.size()) ? held_ids.size() : pref_count;
            held_ids.insert(pos, id);
            held_ages.insert(pos, age);
            pref_count = pos + 1;
          end else begin
            held_ids.push_back(id);
            held_ages.push_back(age);
          end
        end
        FUNC_SERVE: begin
          if (held_ids.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.served = held_ids.pop_front();
            void'(held_ages.pop_front());
            if (pref_count > 0) pref_count--;
          end
        end
        FUNC_QUERY: begin
          if (slot >= 0) r.age = held_ages[slot];
          else r.status = ST_NOTFOUND;
        end
        default: ;
      endcase
      r.len = LenW'(held_ids.size());
      owed_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [IdW-1:0] exp, logic [IdW-1:0] act);
      if (act !== exp) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp, act);
        errors++;
      end
    endfunction

    // Compare a result word with the oldest owed one
    function void check_result(logic [2:0] st, logic [IdW-1:0] sid, logic [AgeW-1:0] age,
                               logic [LenW-1:0] len);
      queue_result_t exp;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result, status %0d served %0d age %0d length %0d",
                 $time, st, sid, age, len);
        errors++;
        return;
      end
      exp = owed_q.pop_front();
      compare_field("status", IdW'(exp.status), IdW'(st));
      compare_field("served_id", exp.served, sid);
      compare_field("reported_age", IdW'(exp.age), IdW'(age));
      compare_field("queue_length", IdW'(exp.len), IdW'(len));
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we;
  logic [AgeW-1:0] cfg_data;
  logic            in_valid;
  logic            in_stall;
  logic [1:0]      func;
  logic [IdW-1:0]  person_id;
  logic [AgeW-1:0] person_age;
  logic            out_valid;
  logic            out_stall;
  logic [2:0]      status;
  logic [IdW-1:0]  served_id;
  logic [AgeW-1:0] reported_age;
  logic [LenW-1:0] queue_length;

  queue_scoreboard sb = new();
  bit              idle_on;
  int unsigned     results_seen;

  two_class_priority_queue #(
    .CAPACITY(QueueDepth)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .person_id_i    (person_id),
    .person_age_i   (person_age),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .served_id_o    (served_id),
    .reported_age_o (reported_age),
    .queue_length_o (queue_length)
  );

  always #5 clk_i = ~clk_i;

  // Offer one word, hold it until accepted, then maybe insert a gap
  task automatic send_word(func_e f, logic [IdW-1:0] id, logic [AgeW-1:0] age);
    in_valid   <= 1'b1;
    func       <= f;
    person_id  <= id;
    person_age <= age;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_word(f, id, age);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Write the threshold once the block has drained
  task automatic set_threshold(logic [AgeW-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.pref_age = value;
  endtask

  // Random words biased toward id collisions and ages near the threshold
  task automatic random_phase(int unsigned count, bit quiet);
    int unsigned     join_pct;
    int unsigned     pick;
    int              near;
    func_e           f;
    logic [IdW-1:0]  id;
    logic [AgeW-1:0] age;
    join_pct = 50;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        join_pct = 25 * $urandom_range(1, 3);
        idle_on  = !quiet && ($urandom_range(0, 9) < 7);
      end
      if ($urandom_range(0, 99) < join_pct) begin
        f = FUNC_JOIN;
      end else begin
        pick = $urandom_range(0, 99);
        f = (pick < 60) ? FUNC_SERVE : (pick < 95) ? FUNC_QUERY : FUNC_NONE;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) id = IdW'($urandom_range(0, 23));
      else if (pick < 85 && sb.held_ids.size() > 0)
        id = sb.held_ids[$urandom_range(0, sb.held_ids.size() - 1)];
      else id = IdW'($urandom);
      if ($urandom_range(0, 1) == 0) begin
        near = int'(sb.pref_age) + $urandom_range(0, 2) - 1;
        age  = (near < 0) ? 8'd0 : (near > 255) ? 8'd255 : AgeW'(near);
      end else begin
        age = AgeW'($urandom);
      end
      send_word(f, id, age);
    end
  endtask

  // Accept results, stall in random bursts, and hold off once for a long stretch
  initial begin : result_sink
    int unsigned stall_left;
    bit          pressure_done;
    stall_left    = 0;
    pressure_done = 0;
    results_seen  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && !out_stall) begin
        sb.check_result(status, served_id, reported_age, queue_length);
        results_seen++;
      end
      if (!pressure_done && results_seen >= 200) begin
        pressure_done = 1;
        stall_left    = 80;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Main sequence
  initial begin
    rst_ni     <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    func       <= FUNC_NONE;
    person_id  <= '0;
    person_age <= '0;
    idle_on     = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty serve, missing id, unused selector, extremes, threshold edge,
    // duplicate, full, duplicate on a full queue, serving preferred heads
    send_word(FUNC_SERVE, '0, '0);
    send_word(FUNC_QUERY, '0, '0);
    send_word(FUNC_NONE, 16'hFFFF, 8'hFF);
    send_word(FUNC_JOIN, 16'h0000, 8'd0);
    send_word(FUNC_JOIN, 16'hFFFF, 8'd255);
    send_word(FUNC_JOIN, 16'h0000, 8'd100);
    send_word(FUNC_JOIN, 16'd100, PrefAgeReset);
    send_word(FUNC_JOIN, 16'd101, PrefAgeReset - 8'd1);
    send_word(FUNC_QUERY, 16'hFFFF, '0);
    send_word(FUNC_QUERY, 16'd101, 8'hFF);
    for (int i = 0; i < 12; i++) send_word(FUNC_JOIN, IdW'(200 + i), AgeW'(i * 21));
    send_word(FUNC_JOIN, 16'd300, 8'd90);
    send_word(FUNC_JOIN, 16'h0000, 8'd5);
    send_word(FUNC_SERVE, '0, '0);
    send_word(FUNC_SERVE, '0, '0);
    send_word(FUNC_QUERY, 16'hFFFF, '0);

    // Random phases across several thresholds, the last one without idling
    set_threshold(8'd0);
    random_phase(275, 0);
    set_threshold(8'd255);
    random_phase(275, 0);
    set_threshold(8'd128);
    random_phase(275, 0);
    set_threshold(AgeW'($urandom));
    random_phase(275, 0);
    set_threshold(PrefAgeReset);
    random_phase(275, 1);

    // Drain and let the pipeline settle
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_two_class_priority_queue: clean");
    end else begin
      $display("tb_two_class_priority_queue: errors");
    end
    $finish;
  end

  // Guard against a hang
  initial begin
    #5_000_000;
    $display("tb_two_class_priority_queue: errors");
    $finish;
  end

endmodule

`default_nettype wire
